>>> hdl/sjh_pkg.sv
// shared types and constants for the sampling jitter histogram unit
// no dependencies
package sjh_pkg;

  localparam int unsigned TS_W   = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned CFGA_W = 1;

  localparam int unsigned BINS_DEF = 256;

  localparam logic [TS_W-1:0]   PERIOD_RST = 32'd80000;
  localparam logic [CNT_W-1:0]  RUN_RST    = 16'd10000;
  localparam logic [CNT_W-1:0]  BIN_FULL   = 16'hFFFF;

  localparam logic [CFGA_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFGA_W-1:0] CFG_RUN    = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             is_read;
    logic             rec;
    logic             idx_ok;
    logic [TS_W-1:0]  dev;
    logic [CNT_W-1:0] events;
  } sjh_s2_t;

endpackage

>>> hdl/sjh_ram.sv
// generic single write port ram with registered read
// no dependencies
module sjh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sjh_meas.sv
// input register, event counter, interval and deviation stage
// depends on sjh_pkg
module sjh_meas #(
  parameter int unsigned BINS = sjh_pkg::BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_acc_i,
  input  logic                          cmd_i,
  input  logic [sjh_pkg::TS_W-1:0]      timestamp_i,
  input  logic [sjh_pkg::IDX_W-1:0]     bin_index_i,
  input  logic [sjh_pkg::TS_W-1:0]      period_i,
  input  logic [sjh_pkg::CNT_W-1:0]     run_i,
  output logic [$clog2(BINS)-1:0]       rd_addr_o,
  output logic [$clog2(BINS)-1:0]       s2_addr_o,
  output sjh_pkg::sjh_s2_t              s2_o
);
  import sjh_pkg::*;

  localparam int unsigned AW = $clog2(BINS);

  logic              s1_valid_q;
  logic              s1_cmd_q;
  logic [TS_W-1:0]   s1_ts_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TS_W-1:0]   prev_q, prev_d;
  logic [AW-1:0]     s2_addr_q;
  sjh_s2_t           s2_q, s2_d;

  logic              counted;
  logic              measured;
  logic [CNT_W-1:0]  count_inc;
  logic [TS_W-1:0]   interval;
  logic [TS_W-1:0]   dev;
  logic [AW-1:0]     slot;

  always_comb begin
    counted   = s1_valid_q && !s1_cmd_q && (count_q < run_i);
    count_inc = count_q + CNT_W'(1);
    measured  = counted && (count_q != '0);
    interval  = s1_ts_q - prev_q;
    dev       = (interval > period_i) ? (interval - period_i) : (period_i - interval);
    slot      = (dev >= TS_W'(BINS)) ? AW'(BINS - 1) : dev[AW-1:0];
    rd_addr_o = s1_cmd_q ? AW'(s1_idx_q) : slot;

    count_d = counted ? count_inc : count_q;
    prev_d  = counted ? s1_ts_q : prev_q;

    s2_d.valid   = s1_valid_q;
    s2_d.is_read = s1_cmd_q;
    s2_d.rec     = measured;
    s2_d.idx_ok  = (TS_W'(s1_idx_q) < TS_W'(BINS));
    s2_d.dev     = measured ? dev : '0;
    s2_d.events  = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      prev_q     <= '0;
      s2_q       <= '0;
    end else if (adv_i) begin
      s1_valid_q <= in_acc_i;
      count_q    <= count_d;
      prev_q     <= prev_d;
      s2_q       <= s2_d;
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_cmd_q  <= cmd_i;
      s1_ts_q   <= timestamp_i;
      s1_idx_q  <= bin_index_i;
      s2_addr_q <= rd_addr_o;
    end
  end

  assign s2_o      = s2_q;
  assign s2_addr_o = s2_addr_q;

endmodule

>>> hdl/sjh_hist.sv
// histogram store with clearing pass, forwarding, bin update and result register
// depends on sjh_pkg and sjh_ram
module sjh_hist #(
  parameter int unsigned BINS = sjh_pkg::BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [$clog2(BINS)-1:0]       rd_addr_i,
  input  logic [$clog2(BINS)-1:0]       s2_addr_i,
  input  sjh_pkg::sjh_s2_t              s2_i,
  input  logic                          out_stall_i,
  output logic                          adv_o,
  output logic                          clr_busy_o,
  output logic                          out_valid_o,
  output logic [sjh_pkg::TS_W-1:0]      deviation_o,
  output logic                          recorded_o,
  output logic [sjh_pkg::CNT_W-1:0]     bin_count_o,
  output logic [sjh_pkg::TS_W-1:0]      max_deviation_o,
  output logic [sjh_pkg::CNT_W-1:0]     events_counted_o
);
  import sjh_pkg::*;

  localparam int unsigned AW = $clog2(BINS);

  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;
  logic              fwd_hit_q;
  logic [CNT_W-1:0]  fwd_data_q;
  logic [TS_W-1:0]   worst_q, worst_d;
  logic              out_valid_q;
  logic [TS_W-1:0]   out_dev_q;
  logic              out_rec_q;
  logic [CNT_W-1:0]  out_bin_q;
  logic [TS_W-1:0]   out_max_q;
  logic [CNT_W-1:0]  out_events_q;

  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  new_count;
  logic              upd_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [CNT_W-1:0]  bin_d;

  assign adv_o = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_count = fwd_hit_q ? fwd_data_q : ram_rdata;
    new_count = (cur_count == BIN_FULL) ? cur_count : cur_count + CNT_W'(1);
    upd_we    = adv_o && s2_i.valid && s2_i.rec;
    ram_we    = clr_q || upd_we;
    ram_waddr = clr_q ? clr_addr_q : s2_addr_i;
    ram_wdata = clr_q ? '0 : new_count;
    worst_d   = (s2_i.rec && (s2_i.dev > worst_q)) ? s2_i.dev : worst_q;
    bin_d     = (s2_i.is_read && s2_i.idx_ok) ? cur_count : '0;
  end

  sjh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv_o),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(BINS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q   <= 1'b0;
      worst_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      fwd_hit_q   <= upd_we && (s2_addr_i == rd_addr_i);
      worst_q     <= (s2_i.valid) ? worst_d : worst_q;
      out_valid_q <= s2_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      fwd_data_q   <= new_count;
      out_dev_q    <= s2_i.dev;
      out_rec_q    <= s2_i.rec;
      out_bin_q    <= bin_d;
      out_max_q    <= worst_d;
      out_events_q <= s2_i.events;
    end
  end

  assign clr_busy_o       = clr_q;
  assign out_valid_o      = out_valid_q;
  assign deviation_o      = out_dev_q;
  assign recorded_o       = out_rec_q;
  assign bin_count_o      = out_bin_q;
  assign max_deviation_o  = out_max_q;
  assign events_counted_o = out_events_q;

endmodule

>>> hdl/sampling_jitter_histogram_unit.sv
// path: an accepted beat goes through the input, deviation and result registers
// throughput: one beat per cycle while the output is not stalled; histogram read-modify-write is forwarded
// reset: counters, previous timestamp and max deviation clear at once, then a
// clearing pass zeroes every histogram bin while input is stalled
// depends on sjh_pkg, sjh_meas, sjh_hist
module sampling_jitter_histogram_unit #(
  parameter int unsigned BINS = sjh_pkg::BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sjh_pkg::CFGA_W-1:0]    cfg_idx_i,
  input  logic [sjh_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [sjh_pkg::TS_W-1:0]      timestamp_i,
  input  logic [sjh_pkg::IDX_W-1:0]     bin_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sjh_pkg::TS_W-1:0]      deviation_o,
  output logic                          recorded_o,
  output logic [sjh_pkg::CNT_W-1:0]     bin_count_o,
  output logic [sjh_pkg::TS_W-1:0]      max_deviation_o,
  output logic [sjh_pkg::CNT_W-1:0]     events_counted_o
);
  import sjh_pkg::*;

  localparam int unsigned AW = $clog2(BINS);

  logic [TS_W-1:0]  period_q;
  logic [CNT_W-1:0] run_q;
  logic             adv;
  logic             clr_busy;
  logic             in_acc;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    s2_addr;
  sjh_s2_t          s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      run_q    <= RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD: period_q <= cfg_data_i[TS_W-1:0];
        CFG_RUN:    run_q    <= cfg_data_i[CNT_W-1:0];
        default:    period_q <= period_q;
      endcase
    end
  end

  assign in_stall_o = clr_busy || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  sjh_meas #(
    .BINS (BINS)
  ) u_meas (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_acc_i    (in_acc),
    .cmd_i       (cmd_i),
    .timestamp_i (timestamp_i),
    .bin_index_i (bin_index_i),
    .period_i    (period_q),
    .run_i       (run_q),
    .rd_addr_o   (rd_addr),
    .s2_addr_o   (s2_addr),
    .s2_o        (s2)
  );

  sjh_hist #(
    .BINS (BINS)
  ) u_hist (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rd_addr_i        (rd_addr),
    .s2_addr_i        (s2_addr),
    .s2_i             (s2),
    .out_stall_i      (out_stall_i),
    .adv_o            (adv),
    .clr_busy_o       (clr_busy),
    .out_valid_o      (out_valid_o),
    .deviation_o      (deviation_o),
    .recorded_o       (recorded_o),
    .bin_count_o      (bin_count_o),
    .max_deviation_o  (max_deviation_o),
    .events_counted_o (events_counted_o)
  );

endmodule
